/* hw/rtl/cia_pkg.sv */
// shared types and constants for the complex integer alu
// no dependencies; imported by cia_mult, cia_sum, cia_div and complex_integer_alu
package cia_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_WIDTH         = 33;

    // operation selector carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // per-beat control that travels down the pipeline
    typedef struct packed {
        func_t func;
        logic  den_zero;
    } ctl_t;

endpackage

/* hw/rtl/cia_mult.sv */
// first pipeline stage: the six operand products and the add/subtract result
// depends on cia_pkg
module cia_mult
    import cia_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  func_t                 func,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    input  logic signed [W-1:0]   c,
    input  logic signed [W-1:0]   d,
    output logic                  out_valid,
    input  logic                  out_ready,
    output func_t                 func_out,
    output logic signed [2*W-1:0] ac,
    output logic signed [2*W-1:0] bd,
    output logic signed [2*W-1:0] bc,
    output logic signed [2*W-1:0] ad,
    output logic signed [2*W-1:0] cc,
    output logic signed [2*W-1:0] dd,
    output logic signed [W:0]     as_re,
    output logic signed [W:0]     as_im
);

    logic                  valid_reg;
    func_t                 func_reg;
    logic signed [2*W-1:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;
    logic signed [W:0]     as_re_reg, as_im_reg;
    logic signed [W:0]     as_re_next, as_im_next;
    logic                  en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // add or subtract, exact at one extra bit
    always_comb
    begin
        if (func == FUNC_SUB)
        begin
            as_re_next = a - c;
            as_im_next = b - d;
        end
        else
        begin
            as_re_next = a + c;
            as_im_next = b + d;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            func_reg  <= func;
            ac_reg    <= a * c;
            bd_reg    <= b * d;
            bc_reg    <= b * c;
            ad_reg    <= a * d;
            cc_reg    <= c * c;
            dd_reg    <= d * d;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
    end

    assign out_valid = valid_reg;
    assign func_out  = func_reg;
    assign ac        = ac_reg;
    assign bd        = bd_reg;
    assign bc        = bc_reg;
    assign ad        = ad_reg;
    assign cc        = cc_reg;
    assign dd        = dd_reg;
    assign as_re     = as_re_reg;
    assign as_im     = as_im_reg;

endmodule

/* hw/rtl/cia_sum.sv */
// second and third stages: product sums, result select, divisor and
// sign/magnitude split of the division numerators
// depends on cia_pkg
module cia_sum
    import cia_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  func_t                  func,
    input  logic signed [2*W-1:0]  ac,
    input  logic signed [2*W-1:0]  bd,
    input  logic signed [2*W-1:0]  bc,
    input  logic signed [2*W-1:0]  ad,
    input  logic signed [2*W-1:0]  cc,
    input  logic signed [2*W-1:0]  dd,
    input  logic signed [W:0]      as_re,
    input  logic signed [W:0]      as_im,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ctl_t                   ctl,
    output logic [RES_WIDTH-1:0]   res_re,
    output logic [RES_WIDTH-1:0]   res_im,
    output logic [2*W-1:0]         den,
    output logic [2*W-1:0]         mag_re,
    output logic [2*W-1:0]         mag_im,
    output logic                   neg_re,
    output logic                   neg_im
);

    localparam int EW = (2 * W + 1 > RES_WIDTH) ? 2 * W + 1 : RES_WIDTH;

    // stage two registers
    logic                   v2_reg;
    ctl_t                   ctl2_reg;
    logic [RES_WIDTH-1:0]   re2_reg, im2_reg;
    logic [2*W-1:0]         den2_reg;
    logic signed [2*W:0]    num_re_reg, num_im_reg;
    // stage three registers
    logic                   v3_reg;
    ctl_t                   ctl3_reg;
    logic [RES_WIDTH-1:0]   re3_reg, im3_reg;
    logic [2*W-1:0]         den3_reg, mag_re_reg, mag_im_reg;
    logic                   neg_re_reg, neg_im_reg;

    logic signed [2*W:0]    mul_re, mul_im, num_re_next, num_im_next;
    logic signed [EW-1:0]   ext_re, ext_im;
    logic [2*W-1:0]         den_next;
    ctl_t                   ctl_next;
    logic [2*W:0]           abs_re, abs_im;
    logic                   en2, en3;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    // sums of products and selection of the non-divide result
    always_comb
    begin
        mul_re      = ac - bd;
        mul_im      = bc + ad;
        num_re_next = ac + bd;
        num_im_next = bc - ad;
        den_next    = $unsigned(cc) + $unsigned(dd);
        unique case (func)
            FUNC_ADD, FUNC_SUB:
            begin
                ext_re = as_re;
                ext_im = as_im;
            end
            FUNC_MUL:
            begin
                ext_re = mul_re;
                ext_im = mul_im;
            end
            default:
            begin
                ext_re = '0;
                ext_im = '0;
            end
        endcase
        ctl_next.func     = func;
        ctl_next.den_zero = (den_next == '0);
    end

    // numerator magnitudes
    always_comb
    begin
        abs_re = num_re_reg[2*W] ? $unsigned(-num_re_reg) : $unsigned(num_re_reg);
        abs_im = num_im_reg[2*W] ? $unsigned(-num_im_reg) : $unsigned(num_im_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en2)
                v2_reg <= in_valid;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en2 && in_valid)
        begin
            ctl2_reg   <= ctl_next;
            re2_reg    <= ext_re[RES_WIDTH-1:0];
            im2_reg    <= ext_im[RES_WIDTH-1:0];
            den2_reg   <= den_next;
            num_re_reg <= num_re_next;
            num_im_reg <= num_im_next;
        end
        if (en3 && v2_reg)
        begin
            ctl3_reg   <= ctl2_reg;
            re3_reg    <= re2_reg;
            im3_reg    <= im2_reg;
            den3_reg   <= den2_reg;
            mag_re_reg <= abs_re[2*W-1:0];
            mag_im_reg <= abs_im[2*W-1:0];
            neg_re_reg <= num_re_reg[2*W];
            neg_im_reg <= num_im_reg[2*W];
        end
    end

    assign out_valid = v3_reg;
    assign ctl       = ctl3_reg;
    assign res_re    = re3_reg;
    assign res_im    = im3_reg;
    assign den       = den3_reg;
    assign mag_re    = mag_re_reg;
    assign mag_im    = mag_im_reg;
    assign neg_re    = neg_re_reg;
    assign neg_im    = neg_im_reg;

endmodule

/* hw/rtl/cia_div.sv */
// pipelined restoring divider, one quotient bit per stage, two lanes that
// share one divisor; side data rides along with each beat
// depends on cia_pkg
module cia_div
    import cia_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ctl_t                 ctl,
    input  logic [RES_WIDTH-1:0] res_re,
    input  logic [RES_WIDTH-1:0] res_im,
    input  logic [2*W-1:0]       den,
    input  logic [2*W-1:0]       mag_re,
    input  logic [2*W-1:0]       mag_im,
    input  logic                 neg_re,
    input  logic                 neg_im,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ctl_t                 ctl_out,
    output logic [RES_WIDTH-1:0] res_re_out,
    output logic [RES_WIDTH-1:0] res_im_out,
    output logic [2*W-1:0]       quot_re,
    output logic [2*W-1:0]       quot_im,
    output logic                 neg_re_out,
    output logic                 neg_im_out
);

    localparam int N  = 2 * W;
    localparam int QW = 2 * W;

    logic                 v_reg      [N];
    logic                 en         [N];
    ctl_t                 ctl_reg    [N];
    logic [RES_WIDTH-1:0] re_reg     [N];
    logic [RES_WIDTH-1:0] im_reg     [N];
    logic [QW-1:0]        den_reg    [N];
    logic [QW-1:0]        rem_re_reg [N];
    logic [QW-1:0]        rem_im_reg [N];
    logic [QW-1:0]        dq_re_reg  [N];
    logic [QW-1:0]        dq_im_reg  [N];
    logic                 nr_reg     [N];
    logic                 ni_reg     [N];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [2*QW-1:0] div_step(input logic [QW-1:0] rem,
                                                 input logic [QW-1:0] dq,
                                                 input logic [QW-1:0] dv);
        logic [QW:0]   t;
        logic [QW:0]   diff;
        logic          fits;
        logic [QW-1:0] rem_n;
        t     = {rem, dq[QW-1]};
        diff  = t - {1'b0, dv};
        fits  = (t >= {1'b0, dv});
        rem_n = fits ? diff[QW-1:0] : t[QW-1:0];
        return {rem_n, dq[QW-2:0], fits};
    endfunction

    assign in_ready = en[0];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_step
            logic                 v_in;
            ctl_t                 ctl_in;
            logic [RES_WIDTH-1:0] re_in, im_in;
            logic [QW-1:0]        den_in, rem_re_in, rem_im_in, dq_re_in, dq_im_in;
            logic                 nr_in, ni_in;
            logic [2*QW-1:0]      st_re, st_im;

            // stage input comes from the ports or from the previous step
            if (i == 0)
            begin : g_head
                assign v_in      = in_valid;
                assign ctl_in    = ctl;
                assign re_in     = res_re;
                assign im_in     = res_im;
                assign den_in    = den;
                assign rem_re_in = '0;
                assign rem_im_in = '0;
                assign dq_re_in  = mag_re;
                assign dq_im_in  = mag_im;
                assign nr_in     = neg_re;
                assign ni_in     = neg_im;
            end
            else
            begin : g_link
                assign v_in      = v_reg[i-1];
                assign ctl_in    = ctl_reg[i-1];
                assign re_in     = re_reg[i-1];
                assign im_in     = im_reg[i-1];
                assign den_in    = den_reg[i-1];
                assign rem_re_in = rem_re_reg[i-1];
                assign rem_im_in = rem_im_reg[i-1];
                assign dq_re_in  = dq_re_reg[i-1];
                assign dq_im_in  = dq_im_reg[i-1];
                assign nr_in     = nr_reg[i-1];
                assign ni_in     = ni_reg[i-1];
            end

            // stall chain
            if (i == N - 1)
            begin : g_tail
                assign en[i] = !v_reg[i] || out_ready;
            end
            else
            begin : g_mid
                assign en[i] = !v_reg[i] || en[i+1];
            end

            assign st_re = div_step(rem_re_in, dq_re_in, den_in);
            assign st_im = div_step(rem_im_in, dq_im_in, den_in);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en[i])
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en[i] && v_in)
                begin
                    ctl_reg[i]    <= ctl_in;
                    re_reg[i]     <= re_in;
                    im_reg[i]     <= im_in;
                    den_reg[i]    <= den_in;
                    rem_re_reg[i] <= st_re[2*QW-1:QW];
                    dq_re_reg[i]  <= st_re[QW-1:0];
                    rem_im_reg[i] <= st_im[2*QW-1:QW];
                    dq_im_reg[i]  <= st_im[QW-1:0];
                    nr_reg[i]     <= nr_in;
                    ni_reg[i]     <= ni_in;
                end
            end
        end
    endgenerate

    assign out_valid  = v_reg[N-1];
    assign ctl_out    = ctl_reg[N-1];
    assign res_re_out = re_reg[N-1];
    assign res_im_out = im_reg[N-1];
    assign quot_re    = dq_re_reg[N-1];
    assign quot_im    = dq_im_reg[N-1];
    assign neg_re_out = nr_reg[N-1];
    assign neg_im_out = ni_reg[N-1];

endmodule

/* hw/rtl/complex_integer_alu.sv */
// top level of the complex integer alu: stream ports, pipeline and output register
// depends on cia_pkg, cia_mult, cia_sum, cia_div
//
// channel  dir  handshake          tdata                       tuser
// s_       in   s_tvalid/s_tready  first/second real and imag  func
// m_       out  m_tvalid/m_tready  result_real, result_imag    status
//
// one beat accepted per cycle unless a full pipeline is held by m_tready low;
// beats pass the product, sum and divider stages and the output register
// every stage holds its own valid bit and advances when the next one is free,
// so bubbles close up and a stall loses or repeats nothing
// rst_n clears all valid bits at once; no clearing pass is needed
module complex_integer_alu
    import cia_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int S_TDATA_W = ((4 * OPERAND_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * RES_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_real, first_imag, second_real, second_imag, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_real, result_imag, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [0:0]           m_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int QE = (2 * W > RES_WIDTH) ? 2 * W : RES_WIDTH;

    // stage one to two
    logic                  v1, r1;
    func_t                 f1;
    logic signed [2*W-1:0] ac, bd, bc, ad, cc, dd;
    logic signed [W:0]     as_re, as_im;
    // stage three to divider
    logic                  v3, r3;
    ctl_t                  ctl3;
    logic [RES_WIDTH-1:0]  re3, im3;
    logic [2*W-1:0]        den3, mre3, mim3;
    logic                  nre3, nim3;
    // divider to output
    logic                  vd, rd;
    ctl_t                  ctld;
    logic [RES_WIDTH-1:0]  red, imd;
    logic [2*W-1:0]        qre, qim;
    logic                  nred, nimd;

    logic                  out_valid_reg;
    logic [RES_WIDTH-1:0]  out_re_reg, out_im_reg, out_re_next, out_im_next;
    logic                  out_st_reg, out_st_next;
    logic [QE-1:0]         qx_re, qx_im;

    cia_mult #(.W(W)) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (func_t'(s_tuser)),
        .a         ($signed(s_tdata[W-1:0])),
        .b         ($signed(s_tdata[2*W-1:W])),
        .c         ($signed(s_tdata[3*W-1:2*W])),
        .d         ($signed(s_tdata[4*W-1:3*W])),
        .out_valid (v1),
        .out_ready (r1),
        .func_out  (f1),
        .ac        (ac),
        .bd        (bd),
        .bc        (bc),
        .ad        (ad),
        .cc        (cc),
        .dd        (dd),
        .as_re     (as_re),
        .as_im     (as_im)
    );

    cia_sum #(.W(W)) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .func      (f1),
        .ac        (ac),
        .bd        (bd),
        .bc        (bc),
        .ad        (ad),
        .cc        (cc),
        .dd        (dd),
        .as_re     (as_re),
        .as_im     (as_im),
        .out_valid (v3),
        .out_ready (r3),
        .ctl       (ctl3),
        .res_re    (re3),
        .res_im    (im3),
        .den       (den3),
        .mag_re    (mre3),
        .mag_im    (mim3),
        .neg_re    (nre3),
        .neg_im    (nim3)
    );

    cia_div #(.W(W)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3),
        .in_ready   (r3),
        .ctl        (ctl3),
        .res_re     (re3),
        .res_im     (im3),
        .den        (den3),
        .mag_re     (mre3),
        .mag_im     (mim3),
        .neg_re     (nre3),
        .neg_im     (nim3),
        .out_valid  (vd),
        .out_ready  (rd),
        .ctl_out    (ctld),
        .res_re_out (red),
        .res_im_out (imd),
        .quot_re    (qre),
        .quot_im    (qim),
        .neg_re_out (nred),
        .neg_im_out (nimd)
    );

    assign rd = !out_valid_reg || m_tready;

    // apply quotient signs and pick the final result
    always_comb
    begin
        qx_re = QE'(qre);
        qx_im = QE'(qim);
        if (nred)
            qx_re = -qx_re;
        if (nimd)
            qx_im = -qx_im;
        out_st_next = 1'b0;
        out_re_next = red;
        out_im_next = imd;
        if (ctld.func == FUNC_DIV)
        begin
            if (ctld.den_zero)
            begin
                out_st_next = 1'b1;
                out_re_next = '0;
                out_im_next = '0;
            end
            else
            begin
                out_re_next = qx_re[RES_WIDTH-1:0];
                out_im_next = qx_im[RES_WIDTH-1:0];
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rd)
            out_valid_reg <= vd;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (rd && vd)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            out_st_reg <= out_st_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_im_reg, out_re_reg});
    assign m_tuser  = out_st_reg;

endmodule

/* hw/rtl/cia_checker.sv */
// port-level checks on the output stream of the complex integer alu
// depends on complex_integer_alu (bound to it below)
module cia_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // no beat offered once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // a stalled beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // zero divisor gives zero parts and zero fill stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero divisor result not zero");

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
